// ===== hdl/ctc_pkg.sv =====
// Shared types, constants and exp tables for the CTC greedy decoder.
// Used by every module of the block but ctc_ram and ctc_checker; depends on nothing.
package ctc_pkg;

  localparam int MAX_CLASSES = 256;
  localparam int MAX_STEPS   = 1024;
  localparam int CLS_W       = 8;                      // class index
  localparam int CC_W        = 9;                      // class count register
  localparam int SC_W        = 11;                     // step count register
  localparam int LOGIT_W     = 16;
  localparam int EXP_W       = 17;                     // exp result, up to 65536
  localparam int SUM_W       = 25;                     // row sum, up to 256*65536
  localparam int PSUM_W      = 27;                     // sum of probabilities
  localparam int PROB_W      = 16;
  localparam int ADDR_W      = CLS_W + 1;              // ping-pong bank + class
  localparam int RAM_DEPTH   = 2 * MAX_CLASSES;
  localparam int NUM_W       = 34;                     // divider dividend
  localparam int DEN_W       = 25;                     // divider divisor
  localparam int DCNT_W      = 6;
  localparam int Q_DEPTH     = 2;
  localparam int QCNT_W      = 2;
  localparam int EXP_K_MAX   = 12;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // register indexes
  localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] REG_STEP_COUNT  = 2'd1;
  localparam logic [1:0] REG_KEY_COUNT   = 2'd2;
  localparam logic [1:0] REG_BLANK_INDEX = 2'd3;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                      bank;
    logic signed [LOGIT_W-1:0] best_value;
    logic [CLS_W-1:0]          best_class;
  } row_desc_t;

  typedef struct packed {
    logic      valid;   // a finished row waits at the queue head
    row_desc_t desc;
  } row_head_t;

  typedef struct packed {
    logic [CC_W-1:0]  class_count;  // effective, 2..256
    logic [SC_W-1:0]  step_count;   // effective, 1..1024
    logic [CLS_W-1:0] key_count;
    logic [CC_W-1:0]  blank;        // resolved blank class
  } cfg_eff_t;

  typedef enum logic [12:0] {
    B_IDLE  = 13'b0000000000001,
    B_WALK  = 13'b0000000000010,
    B_DRAIN = 13'b0000000000100,
    B_PWAIT = 13'b0000000001000,
    B_DECID = 13'b0000000010000,
    B_CHAR  = 13'b0000000100000,
    B_STEP  = 13'b0000001000000,
    B_CDIV  = 13'b0000010000000,
    B_CWAIT = 13'b0000100000000,
    B_RDIV  = 13'b0001000000000,
    B_RWAIT = 13'b0010000000000,
    B_SUM   = 13'b0100000000000,
    B_POP   = 13'b1000000000000
  } back_state_t;

  function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] k);
    logic [EXP_W-1:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] h);
    logic [EXP_W-1:0] r;
    case (h)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] l);
    logic [EXP_W-1:0] r;
    case (l)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65280;
      4'd2:    r = 17'd65026;
      4'd3:    r = 17'd64772;
      4'd4:    r = 17'd64520;
      4'd5:    r = 17'd64268;
      4'd6:    r = 17'd64018;
      4'd7:    r = 17'd63768;
      4'd8:    r = 17'd63520;
      4'd9:    r = 17'd63272;
      4'd10:   r = 17'd63025;
      4'd11:   r = 17'd62780;
      4'd12:   r = 17'd62535;
      4'd13:   r = 17'd62291;
      4'd14:   r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ctc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package.
module ctc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ctc_front.sv =====
// Front end: takes logits, writes each row into one RAM bank, tracks the
// row maximum and queues a descriptor per finished row. Uses ctc_pkg.
module ctc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clear,
  input  logic [ctc_pkg::CC_W-1:0]          class_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ctc_pkg::LOGIT_W-1:0] in_logit,
  output logic                              wr_en,
  output logic [ctc_pkg::ADDR_W-1:0]        wr_addr,
  output logic [ctc_pkg::LOGIT_W-1:0]       wr_data,
  output ctc_pkg::row_head_t                head,
  input  logic                              pop
);

  logic [ctc_pkg::CLS_W-1:0]          idx_r, idx_nxt;
  logic signed [ctc_pkg::LOGIT_W-1:0] best_r, best_nxt;
  logic [ctc_pkg::CLS_W-1:0]          bcls_r, bcls_nxt;
  logic                               bank_r, bank_nxt;
  ctc_pkg::row_desc_t                 q_r [ctc_pkg::Q_DEPTH];
  logic                               wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ctc_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               acc, row_end, push;
  logic                               take;

  assign in_ready = (cnt_r != ctc_pkg::QCNT_W'(ctc_pkg::Q_DEPTH));
  assign acc      = in_valid && in_ready;
  assign row_end  = acc && ({1'b0, idx_r} == class_count - 1'b1);
  assign push     = row_end;

  assign wr_en   = acc;
  assign wr_addr = {bank_r, idx_r};
  assign wr_data = in_logit;

  assign take = (idx_r == '0) || (in_logit > best_r);

  always_comb begin
    idx_nxt  = idx_r;
    best_nxt = best_r;
    bcls_nxt = bcls_r;
    bank_nxt = bank_r;
    if (acc) begin
      if (take) begin
        best_nxt = in_logit;
        bcls_nxt = idx_r;
      end
      if (row_end) begin
        idx_nxt  = '0;
        bank_nxt = ~bank_r;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + ctc_pkg::QCNT_W'(push) - ctc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      idx_r  <= '0;
      best_r <= '0;
      bcls_r <= '0;
      bank_r <= 1'b0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      idx_r  <= idx_nxt;
      best_r <= best_nxt;
      bcls_r <= bcls_nxt;
      bank_r <= bank_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{bank: bank_r, best_value: best_nxt, best_class: bcls_nxt};
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.desc  = q_r[rp_r];

endmodule

// ===== hdl/ctc_exp.sv =====
// Three-stage pipelined fixed-point exp(-d) for d in Q8, result in Q16.
// Uses the tables in ctc_pkg.
module ctc_exp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [ctc_pkg::LOGIT_W-1:0]  d,
  output logic                         out_vld,
  output logic [ctc_pkg::EXP_W-1:0]    e
);

  localparam int P_W = 2 * ctc_pkg::EXP_W;

  logic           v1_r, v2_r, v3_r;
  logic [P_W-1:0] p1_r, p2_r;
  logic [3:0]     lo1_r;
  logic           z1_r, z2_r;
  logic [P_W-1:0] r1;
  logic [ctc_pkg::EXP_W-1:0] a1;

  assign r1 = p1_r + P_W'(32768);
  assign a1 = r1[16 +: ctc_pkg::EXP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= ctc_pkg::exp_int(d[11:8]) * ctc_pkg::exp_hi(d[7:4]);
    lo1_r <= d[3:0];
    z1_r  <= (d[15:8] >= 8'(ctc_pkg::EXP_K_MAX));
    p2_r  <= a1 * ctc_pkg::exp_lo(lo1_r);
    z2_r  <= z1_r;
  end

  logic [P_W-1:0] r2;
  assign r2 = p2_r + P_W'(32768);

  logic [ctc_pkg::EXP_W-1:0] e_r;
  always_ff @(posedge clk) begin
    e_r <= z2_r ? '0 : r2[16 +: ctc_pkg::EXP_W];
  end

  assign out_vld = v3_r;
  assign e       = e_r;

endmodule

// ===== hdl/ctc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Uses ctc_pkg widths.
module ctc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ctc_pkg::NUM_W-1:0]   num,
  input  logic [ctc_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [ctc_pkg::NUM_W-1:0]   quot
);

  logic                         busy_r, done_r;
  logic [ctc_pkg::DCNT_W-1:0]   cnt_r;
  logic [ctc_pkg::NUM_W-1:0]    q_r;
  logic [ctc_pkg::DEN_W-1:0]    den_r;
  logic [ctc_pkg::DEN_W:0]      rem_r, t, t_sub;
  logic                         ge;

  assign t     = {rem_r[ctc_pkg::DEN_W-1:0], q_r[ctc_pkg::NUM_W-1]};
  assign ge    = (t >= {1'b0, den_r});
  assign t_sub = t - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ctc_pkg::DCNT_W'(ctc_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? t_sub : t;
      q_r   <= {q_r[ctc_pkg::NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hdl/ctc_back.sv =====
// Back end: walks a stored row through the exp pipe, divides for the
// probability, decides on characters and builds summaries. Uses ctc_pkg,
// ctc_exp and ctc_div.
module ctc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  ctc_pkg::cfg_eff_t            cfg,
  input  ctc_pkg::row_head_t           head,
  output logic                         pop,
  output logic                         rd_en,
  output logic [ctc_pkg::ADDR_W-1:0]   rd_addr,
  input  logic [ctc_pkg::LOGIT_W-1:0]  rd_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [ctc_pkg::CLS_W-1:0]    out_class_index,
  output logic [ctc_pkg::PROB_W-1:0]   out_char_prob,
  output logic [ctc_pkg::SC_W-1:0]     out_emitted_count,
  output logic [ctc_pkg::PROB_W-1:0]   out_confidence,
  output logic [ctc_pkg::PROB_W-1:0]   out_blank_ratio,
  output logic                         out_last
);

  ctc_pkg::back_state_t st_r, st_nxt;

  ctc_pkg::row_desc_t              row_r;
  logic [ctc_pkg::CC_W-1:0]        iss_r, rcv_r;
  logic [ctc_pkg::SUM_W-1:0]       sum_r;
  logic [ctc_pkg::PROB_W-1:0]      prob_r, conf_r;
  logic [ctc_pkg::CC_W-1:0]        prev_r;
  logic                            prev_vld_r;
  logic [ctc_pkg::SC_W-1:0]        step_r, blank_r, emit_r;
  logic [ctc_pkg::PSUM_W-1:0]      psum_r;
  logic                            rd_pend_r;
  logic                            emit_now, is_blank, out_free;

  logic                            e_vld;
  logic [ctc_pkg::EXP_W-1:0]       e_val;
  logic [ctc_pkg::LOGIT_W:0]       diff;

  logic                            div_start, div_done;
  logic [ctc_pkg::NUM_W-1:0]       div_num, div_q;
  logic [ctc_pkg::DEN_W-1:0]       div_den;
  logic [ctc_pkg::PROB_W-1:0]      q_sat;

  logic                            ov_r;
  logic                            ok_r, olast_r;
  logic [ctc_pkg::CLS_W-1:0]       ocls_r;
  logic [ctc_pkg::PROB_W-1:0]      oprob_r, oconf_r, oratio_r;
  logic [ctc_pkg::SC_W-1:0]        oemit_r;
  logic                            load_char, load_sum;

  assign diff = {row_r.best_value[ctc_pkg::LOGIT_W-1], row_r.best_value}
              - {rd_data[ctc_pkg::LOGIT_W-1], rd_data};

  ctc_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_pend_r),
    .d       (diff[ctc_pkg::LOGIT_W-1:0]),
    .out_vld (e_vld),
    .e       (e_val)
  );

  ctc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign q_sat = (div_q > ctc_pkg::NUM_W'(16'hFFFF)) ? 16'hFFFF
               : div_q[ctc_pkg::PROB_W-1:0];

  assign rd_en   = (st_r == ctc_pkg::B_WALK);
  assign rd_addr = {row_r.bank, iss_r[ctc_pkg::CLS_W-1:0]};

  assign is_blank = ({1'b0, row_r.best_class} == cfg.blank);
  assign emit_now = !is_blank
                  && !(prev_vld_r && ({1'b0, row_r.best_class} == prev_r))
                  && (row_r.best_class < cfg.key_count);

  assign out_free  = !ov_r || out_ready;
  assign load_char = (st_r == ctc_pkg::B_CHAR) && out_free;
  assign load_sum  = (st_r == ctc_pkg::B_SUM) && out_free;
  assign pop       = (st_r == ctc_pkg::B_POP);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st_r)
      ctc_pkg::B_POP: begin
        div_start = 1'b1;
        div_num   = (ctc_pkg::NUM_W'(1) << 32) + ctc_pkg::NUM_W'(sum_r >> 1);
        div_den   = sum_r;
      end
      ctc_pkg::B_CDIV: begin
        div_start = (emit_r != '0);
        div_num   = ctc_pkg::NUM_W'(psum_r) + ctc_pkg::NUM_W'(emit_r >> 1);
        div_den   = ctc_pkg::DEN_W'(emit_r);
      end
      ctc_pkg::B_RDIV: begin
        div_start = 1'b1;
        div_num   = (ctc_pkg::NUM_W'(blank_r) << 16)
                  + ctc_pkg::NUM_W'(cfg.step_count >> 1);
        div_den   = ctc_pkg::DEN_W'(cfg.step_count);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ctc_pkg::B_IDLE:  if (head.valid) st_nxt = ctc_pkg::B_WALK;
      ctc_pkg::B_WALK:  if (iss_r == cfg.class_count - 1'b1) st_nxt = ctc_pkg::B_DRAIN;
      ctc_pkg::B_DRAIN: if (rcv_r == cfg.class_count) st_nxt = ctc_pkg::B_POP;
      ctc_pkg::B_POP:   st_nxt = ctc_pkg::B_PWAIT;
      ctc_pkg::B_PWAIT: if (div_done) st_nxt = ctc_pkg::B_DECID;
      ctc_pkg::B_DECID: st_nxt = emit_now ? ctc_pkg::B_CHAR : ctc_pkg::B_STEP;
      ctc_pkg::B_CHAR:  if (out_free) st_nxt = ctc_pkg::B_STEP;
      ctc_pkg::B_STEP:  st_nxt = (step_r >= cfg.step_count) ? ctc_pkg::B_CDIV
                                                            : ctc_pkg::B_IDLE;
      ctc_pkg::B_CDIV:  st_nxt = (emit_r != '0) ? ctc_pkg::B_CWAIT : ctc_pkg::B_RDIV;
      ctc_pkg::B_CWAIT: if (div_done) st_nxt = ctc_pkg::B_RDIV;
      ctc_pkg::B_RDIV:  st_nxt = ctc_pkg::B_RWAIT;
      ctc_pkg::B_RWAIT: if (div_done) st_nxt = ctc_pkg::B_SUM;
      ctc_pkg::B_SUM:   if (out_free) st_nxt = ctc_pkg::B_IDLE;
      default:          st_nxt = ctc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      st_r       <= ctc_pkg::B_IDLE;
      prev_vld_r <= 1'b0;
      prev_r     <= '0;
      step_r     <= '0;
      blank_r    <= '0;
      emit_r     <= '0;
      psum_r     <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rd_pend_r <= rd_en;
      if (st_r == ctc_pkg::B_DECID) begin
        prev_vld_r <= 1'b1;
        prev_r     <= {1'b0, row_r.best_class};
        step_r     <= step_r + 1'b1;
        if (is_blank) blank_r <= blank_r + 1'b1;
        if (emit_now) begin
          emit_r <= emit_r + 1'b1;
          psum_r <= psum_r + ctc_pkg::PSUM_W'(prob_r);
        end
      end
      // frame over: back to reset values
      if (load_sum) begin
        prev_vld_r <= 1'b0;
        step_r     <= '0;
        blank_r    <= '0;
        emit_r     <= '0;
        psum_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ctc_pkg::B_IDLE) begin
      row_r <= head.desc;
      iss_r <= '0;
      rcv_r <= '0;
      sum_r <= '0;
    end else begin
      if (rd_en) iss_r <= iss_r + 1'b1;
      if (e_vld) begin
        rcv_r <= rcv_r + 1'b1;
        sum_r <= sum_r + ctc_pkg::SUM_W'(e_val);
      end
    end
    if (st_r == ctc_pkg::B_PWAIT && div_done) prob_r <= q_sat;
    if (st_r == ctc_pkg::B_CDIV) conf_r <= '0;
    if (st_r == ctc_pkg::B_CWAIT && div_done) conf_r <= q_sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ov_r <= 1'b0;
    end else if (load_char || load_sum) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  // ratio quotient stays in the divider until the summary loads
  always_ff @(posedge clk) begin
    if (load_char) begin
      ok_r     <= ctc_pkg::KIND_CHAR;
      ocls_r   <= row_r.best_class;
      oprob_r  <= prob_r;
      oemit_r  <= '0;
      oconf_r  <= '0;
      oratio_r <= '0;
      olast_r  <= 1'b0;
    end else if (load_sum) begin
      ok_r     <= ctc_pkg::KIND_SUMMARY;
      ocls_r   <= '0;
      oprob_r  <= '0;
      oemit_r  <= emit_r;
      oconf_r  <= conf_r;
      oratio_r <= q_sat;
      olast_r  <= 1'b1;
    end
  end

  assign out_valid         = ov_r;
  assign out_kind          = ok_r;
  assign out_class_index   = ocls_r;
  assign out_char_prob     = oprob_r;
  assign out_emitted_count = oemit_r;
  assign out_confidence    = oconf_r;
  assign out_blank_ratio   = oratio_r;
  assign out_last          = olast_r;

endmodule

// ===== hdl/ctc_greedy_decoder.sv =====
// Top level of the CTC greedy decoder: APB registers, front end, row RAM
// and back end. Uses ctc_pkg, ctc_front, ctc_ram and ctc_back.
//
//   channel   handshake                  payload
//   in        in_valid / in_ready        in_logit
//   out       out_valid / out_ready      out_kind .. out_last
//   cfg       psel penable pwrite pready paddr pwdata / prdata
//
// Logits enter at one per cycle while fewer than two rows wait unpopped.
// The back end walks a row, drains the exp pipe, divides for the
// probability and decides, then loads a character if one goes out.
// A frame's last row adds the summary divides (confidence only with characters).
// Output stalls hold the back end; two RAM banks let the next row fill.
// Reset is synchronous; a register write restarts the frame.
module ctc_greedy_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_logit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [7:0]                    out_class_index,
  output logic [15:0]                   out_char_prob,
  output logic [10:0]                   out_emitted_count,
  output logic [15:0]                   out_confidence,
  output logic [15:0]                   out_blank_ratio,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctc_pkg::PADDR_W-1:0]   paddr,
  input  logic [ctc_pkg::PDATA_W-1:0]   pwdata,
  output logic [ctc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [ctc_pkg::CC_W-1:0]  cls_r;
  logic [ctc_pkg::SC_W-1:0]  stp_r;
  logic [ctc_pkg::CLS_W-1:0] key_r;
  logic [ctc_pkg::CC_W-1:0]  blk_r;
  logic                      wr, clear;
  ctc_pkg::cfg_eff_t         cfg;
  logic [ctc_pkg::CC_W-1:0]  cc_eff;
  logic                      blk_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign clear  = wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= ctc_pkg::CC_W'(2);
      stp_r <= ctc_pkg::SC_W'(1);
      key_r <= ctc_pkg::CLS_W'(1);
      blk_r <= '1;
    end else if (wr) begin
      case (paddr[3:2])
        ctc_pkg::REG_CLASS_COUNT: cls_r <= pwdata[ctc_pkg::CC_W-1:0];
        ctc_pkg::REG_STEP_COUNT:  stp_r <= pwdata[ctc_pkg::SC_W-1:0];
        ctc_pkg::REG_KEY_COUNT:   key_r <= pwdata[ctc_pkg::CLS_W-1:0];
        ctc_pkg::REG_BLANK_INDEX: blk_r <= pwdata[ctc_pkg::CC_W-1:0];
        default:                  cls_r <= cls_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ctc_pkg::REG_CLASS_COUNT: prdata = ctc_pkg::PDATA_W'(cls_r);
      ctc_pkg::REG_STEP_COUNT:  prdata = ctc_pkg::PDATA_W'(stp_r);
      ctc_pkg::REG_KEY_COUNT:   prdata = ctc_pkg::PDATA_W'(key_r);
      ctc_pkg::REG_BLANK_INDEX: prdata = ctc_pkg::PDATA_W'(blk_r);
      default:                  prdata = '0;
    endcase
  end

  // clamp counts and resolve the blank class
  always_comb begin
    if (cls_r < ctc_pkg::CC_W'(2))                       cc_eff = ctc_pkg::CC_W'(2);
    else if (cls_r > ctc_pkg::CC_W'(ctc_pkg::MAX_CLASSES)) cc_eff = ctc_pkg::CC_W'(ctc_pkg::MAX_CLASSES);
    else                                                 cc_eff = cls_r;
    cfg.class_count = cc_eff;
    if (stp_r == '0)                                     cfg.step_count = ctc_pkg::SC_W'(1);
    else if (stp_r > ctc_pkg::SC_W'(ctc_pkg::MAX_STEPS))  cfg.step_count = ctc_pkg::SC_W'(ctc_pkg::MAX_STEPS);
    else                                                 cfg.step_count = stp_r;
    cfg.key_count = key_r;
    blk_out = blk_r[ctc_pkg::CC_W-1] || (blk_r >= cc_eff);
    if (!blk_out)                                   cfg.blank = blk_r;
    else if (cc_eff == {1'b0, key_r} + 1'b1)        cfg.blank = {1'b0, key_r};
    else                                            cfg.blank = cc_eff - 1'b1;
  end

  logic                          wr_en, rd_en, pop;
  logic [ctc_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
  logic [ctc_pkg::LOGIT_W-1:0]   wr_data, rd_data;
  ctc_pkg::row_head_t            head;

  ctc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (clear),
    .class_count (cc_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_logit    (in_logit),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .head        (head),
    .pop         (pop)
  );

  ctc_ram #(
    .WIDTH (ctc_pkg::LOGIT_W),
    .DEPTH (ctc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ctc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .clear             (clear),
    .cfg               (cfg),
    .head              (head),
    .pop               (pop),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_class_index   (out_class_index),
    .out_char_prob     (out_char_prob),
    .out_emitted_count (out_emitted_count),
    .out_confidence    (out_confidence),
    .out_blank_ratio   (out_blank_ratio),
    .out_last          (out_last)
  );

endmodule

// ===== hdl/ctc_checker.sv =====
// Port-level checks for the CTC greedy decoder, bound to the top level.
// Depends only on the top level's ports.
module ctc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic        out_last,
  input logic [7:0]  out_class_index,
  input logic [10:0] out_emitted_count,
  input logic [15:0] out_confidence,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
                                && $stable(out_class_index))
    else $error("result changed while stalled");

  a_last_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind))
    else $error("last flag does not match summary kind");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_emitted_count == 11'd0 && out_confidence == 16'd0)
    else $error("summary fields set on a character");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind ctc_greedy_decoder ctc_checker u_ctc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_last          (out_last),
  .out_class_index   (out_class_index),
  .out_emitted_count (out_emitted_count),
  .out_confidence    (out_confidence),
  .pready            (pready)
);

// ===== dv/ctc_greedy_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the CTC greedy decoder: APB register setup, logit
// stream with random idling, character and summary items checked against a
// built-in predictor. Depends on ctc_pkg and ctc_greedy_decoder.
module ctc_greedy_decoder_tb;

  typedef struct {
    logic        kind;
    logic [7:0]  class_index;
    logic [15:0] char_prob;
    logic [10:0] emitted_count;
    logic [15:0] confidence;
    logic [15:0] blank_ratio;
    logic        last;
  } decode_item_t;

  typedef struct {
    logic [15:0] logit;
    logic        has_exp;   // typed-in expectation for the first item this logit causes
    decode_item_t exp_item;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_logit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [7:0] out_class_index;
  logic [15:0] out_char_prob;
  logic [10:0] out_emitted_count;
  logic [15:0] out_confidence;
  logic [15:0] out_blank_ratio;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ctc_pkg::PADDR_W-1:0] paddr = '0;
  logic [ctc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ctc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  ctc_greedy_decoder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned cls_reg, steps_reg, keys_reg, blank_reg;
  int signed   row_vals [ctc_pkg::MAX_CLASSES];
  int signed   top_value;
  int unsigned top_class, col_cnt, step_cnt, blank_cnt, char_cnt, prob_acc;
  int signed   prev_top;
  decode_item_t pending_items[$];
  decode_item_t first_new;
  int new_cnt = 0;

  int errors = 0;
  int checked = 0;
  int chars_seen = 0;
  int frames_seen = 0;
  int sent = 0;
  int idle_pct = 27;

  function automatic int unsigned exp_table_int(int unsigned k);
    int unsigned t[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    return t[k];
  endfunction
  function automatic int unsigned exp_table_hi(int unsigned h);
    int unsigned t[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                           39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    return t[h];
  endfunction
  function automatic int unsigned exp_table_lo(int unsigned l);
    int unsigned t[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                           63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};
    return t[l];
  endfunction

  function automatic longint unsigned neg_exp(int unsigned d);
    longint unsigned a;
    if ((d >> 8) >= 12) return 0;
    a = (longint'(exp_table_int(d >> 8)) * exp_table_hi((d >> 4) & 15) + 32768) >> 16;
    a = (a * exp_table_lo(d & 15) + 32768) >> 16;
    return a;
  endfunction

  function automatic int unsigned classes_eff();
    if (cls_reg < 2) return 2;
    if (cls_reg > ctc_pkg::MAX_CLASSES) return ctc_pkg::MAX_CLASSES;
    return cls_reg;
  endfunction
  function automatic int unsigned steps_eff();
    if (steps_reg < 1) return 1;
    if (steps_reg > ctc_pkg::MAX_STEPS) return ctc_pkg::MAX_STEPS;
    return steps_reg;
  endfunction

  function automatic void clear_frame();
    top_value = -32768; top_class = 0; prev_top = -1;
    col_cnt = 0; step_cnt = 0; blank_cnt = 0; char_cnt = 0; prob_acc = 0;
  endfunction

  function automatic bit same_item(decode_item_t a, decode_item_t b);
    return a.kind === b.kind && a.class_index === b.class_index &&
           a.char_prob === b.char_prob && a.emitted_count === b.emitted_count &&
           a.confidence === b.confidence && a.blank_ratio === b.blank_ratio &&
           a.last === b.last;
  endfunction

  function automatic void push_item(decode_item_t it);
    if (new_cnt == 0) first_new = it;
    new_cnt++;
    pending_items.push_back(it);
  endfunction

  function automatic void decode_logit(logic [15:0] raw);
    int signed v;
    int unsigned cc, idx, c, ratio, conf, nsteps;
    longint unsigned row_sum, prob;
    int signed bl;
    decode_item_t it;
    new_cnt = 0;
    v = $signed(raw);
    cc = classes_eff();
    idx = col_cnt;
    if (idx >= ctc_pkg::MAX_CLASSES) idx = ctc_pkg::MAX_CLASSES - 1;
    row_vals[idx] = v;
    if (idx == 0 || v > top_value) begin
      top_value = v;
      top_class = idx;
    end
    col_cnt = idx + 1;
    if (col_cnt < cc) return;
    col_cnt = 0;
    row_sum = 0;
    for (c = 0; c < cc; c++) row_sum += neg_exp(top_value - row_vals[c]);
    if (row_sum == 0) row_sum = 1;
    prob = ((64'd1 << 32) + row_sum / 2) / row_sum;
    if (prob > 65535) prob = 65535;
    bl = $signed(blank_reg[8:0]);
    if (bl < 0 || bl >= int'(cc)) bl = (cc == keys_reg + 1) ? int'(keys_reg) : int'(cc) - 1;
    if (int'(top_class) == bl) blank_cnt++;
    if (!(int'(top_class) == bl || int'(top_class) == prev_top) && top_class < keys_reg) begin
      it = '{default: '0};
      it.kind = ctc_pkg::KIND_CHAR;
      it.class_index = top_class[7:0];
      it.char_prob = prob[15:0];
      push_item(it);
      char_cnt++;
      prob_acc += prob;
    end
    prev_top = top_class;
    step_cnt++;
    nsteps = steps_eff();
    if (step_cnt >= nsteps) begin
      conf = 0;
      if (char_cnt > 0) conf = (prob_acc + char_cnt / 2) / char_cnt;
      if (conf > 65535) conf = 65535;
      ratio = ((longint'(blank_cnt) << 16) + nsteps / 2) / nsteps;
      if (ratio > 65535) ratio = 65535;
      it = '{default: '0};
      it.kind = ctc_pkg::KIND_SUMMARY;
      it.emitted_count = char_cnt[10:0];
      it.confidence = conf[15:0];
      it.blank_ratio = ratio[15:0];
      it.last = 1'b1;
      push_item(it);
      clear_frame();
    end
  endfunction

  task automatic reg_write(logic [1:0] idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ctc_pkg::PADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ctc_pkg::REG_CLASS_COUNT: cls_reg = value & 'h1FF;
      ctc_pkg::REG_STEP_COUNT:  steps_reg = value & 'h7FF;
      ctc_pkg::REG_KEY_COUNT:   keys_reg = value & 'hFF;
      default:                  blank_reg = value & 'h1FF;
    endcase
    clear_frame();
  endtask

  task automatic configure(int unsigned cc, int unsigned sc, int unsigned kc, int signed bi);
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (pending_items.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (cc + 120) @(posedge clk);  // row may still be in the exp pipe
    reg_write(ctc_pkg::REG_CLASS_COUNT, cc);
    reg_write(ctc_pkg::REG_STEP_COUNT, sc);
    reg_write(ctc_pkg::REG_KEY_COUNT, kc);
    reg_write(ctc_pkg::REG_BLANK_INDEX, bi & 'h1FF);
  endtask

  // valid drops only while idling, so it gets one assignment per edge
  task automatic send_logit(logic [15:0] value);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_logit <= value;
    decode_logit(value);
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] rand_logit(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1536)) - 16'd768;   // close values, real softmax
      default: return 16'($urandom_range(0, 3)) << 8;    // many ties
    endcase
  endfunction

  // consumer side and checker
  always @(posedge clk) begin
    decode_item_t want;
    if (rst_n && out_valid && out_ready) begin
      checked++;
      if (pending_items.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item kind=%0d class=%0d", out_kind,
                                   out_class_index);
      end else begin
        want = pending_items.pop_front();
        if (out_kind == ctc_pkg::KIND_SUMMARY) frames_seen++; else chars_seen++;
        if (out_kind !== want.kind || out_class_index !== want.class_index ||
            out_char_prob !== want.char_prob || out_emitted_count !== want.emitted_count ||
            out_confidence !== want.confidence || out_blank_ratio !== want.blank_ratio ||
            out_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp k%0d c%0d p%0d n%0d f%0d b%0d l%0d, got k%0d c%0d p%0d n%0d f%0d b%0d l%0d",
                     want.kind, want.class_index, want.char_prob, want.emitted_count,
                     want.confidence, want.blank_ratio, want.last, out_kind, out_class_index,
                     out_char_prob, out_emitted_count, out_confidence, out_blank_ratio,
                     out_last);
        end
      end
    end
    out_ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
  end

  stim_row_t directed[$];

  task automatic add_row(logic [15:0] v, bit has, decode_item_t e);
    stim_row_t r;
    r.logit = v; r.has_exp = has; r.exp_item = e;
    directed.push_back(r);
  endtask

  initial begin
    decode_item_t none, e;
    int n, i, frames, cc, sc, kc, bi, mode;
    none = '{default: '0};
    cls_reg = 2; steps_reg = 1; keys_reg = 1; blank_reg = 'h1FF;
    for (i = 0; i < ctc_pkg::MAX_CLASSES; i++) row_vals[i] = 0;
    clear_frame();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: 2 classes, 1 step, key 1, blank auto -> class 1.
    // tie at class 0: character 0 with prob 1/2, then summary.
    e = none; e.char_prob = 16'd32768; add_row(16'h0000, 0, none); add_row(16'h0000, 1, e);
    // extremes: class 1 far above -> blank, summary only
    e = none; e.kind = ctc_pkg::KIND_SUMMARY; e.blank_ratio = 16'd65535; e.last = 1'b1;
    add_row(16'h8000, 0, none); add_row(16'h7FFF, 1, e);
    // class 0 far above: saturated prob
    e = none; e.char_prob = 16'd65535;
    add_row(16'h7FFF, 0, none); add_row(16'h8000, 1, e);
    add_row(16'h0001, 0, none); add_row(16'h0000, 0, none);
    foreach (directed[k]) begin
      send_logit(directed[k].logit);
      if (directed[k].has_exp) begin
        if (new_cnt == 0 || !same_item(first_new, directed[k].exp_item)) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: predictor disagrees with typed result", k);
        end
      end
    end

    // more directed settings: max classes, key 0, explicit blank, clamps
    configure(256, 3, 255, 0);
    for (i = 0; i < 768; i++) send_logit(i == 5 ? 16'h7FFF : (i == 300 ? 16'h8000 : 16'(i)));
    configure(0, 0, 0, 300);
    for (i = 0; i < 6; i++) send_logit(16'($urandom));
    configure(511, 2047, 3, 2);
    for (i = 0; i < 20; i++) send_logit(16'($urandom));  // frame abandoned by the write
    configure(4, 5, 3, -1);
    for (i = 0; i < 20; i++) send_logit(rand_logit(2));

    // random frames: mostly small shapes, a few large single-step ones
    frames = 0;
    while (sent < 1600) begin
      if ($urandom_range(9) == 0) idle_pct = 0; else idle_pct = 27;
      if (frames % 6 == 0) begin
        if ($urandom_range(19) == 0) begin
          cc = $urandom_range(100, 256);
          sc = 1;
        end else begin
          cc = $urandom_range(2, 8);
          sc = $urandom_range(1, 12);
        end
        kc = $urandom_range(0, cc);
        bi = $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, cc + 1);
        configure(cc, sc, kc, bi);
      end
      mode = $urandom_range(2);
      for (i = 0; i < classes_eff() * steps_eff(); i++) begin
        send_logit(rand_logit(mode));
      end
      frames++;
    end
    in_valid <= 1'b0;
    idle_pct = 27;
    n = 0;
    while (pending_items.size() != 0 && n < 300000) begin
      @(posedge clk);
      n++;
    end
    repeat (400) @(posedge clk);
    $display("run: %0d logits sent, %0d items checked", sent, checked);
    $display("run: %0d characters and %0d frame summaries", chars_seen, frames_seen);
    if (errors == 0 && pending_items.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/ctc_pkg.sv
hdl/ctc_ram.sv
hdl/ctc_front.sv
hdl/ctc_exp.sv
hdl/ctc_div.sv
hdl/ctc_back.sv
hdl/ctc_greedy_decoder.sv
hdl/ctc_checker.sv
dv/ctc_greedy_decoder_tb.sv
